// ----- rtl/pvng_pkg.sv -----
// pvng_pkg: shared types, register indexes and the velocity curve function
// for the pad velocity note gate; no dependencies

package pvng_pkg;

    localparam int PAD_W      = 4;
    localparam int PRESSURE_W = 12;
    localparam int TIME_W     = 16;
    localparam int LEVEL_W    = 16;
    localparam int MIDI_W     = 7;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DELAY_MS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE        = 3'd5;

    localparam logic [LEVEL_W-1:0] THRESHOLD_ON_RST     = 16'd2621;
    localparam logic [LEVEL_W-1:0] THRESHOLD_OFF_RST    = 16'd655;
    localparam logic [LEVEL_W-1:0] SMOOTHING_WEIGHT_RST = 16'd52429;
    localparam logic [DELAY_W-1:0] ON_DELAY_RST         = 8'd5;
    localparam logic [DELAY_W-1:0] OFF_DELAY_RST        = 8'd10;
    localparam logic [MIDI_W-1:0]  BASE_NOTE_RST        = 7'd36;

    typedef enum logic [3:0] {
        GATE_OFF     = 4'b0001,
        GATE_RISING  = 4'b0010,
        GATE_ON      = 4'b0100,
        GATE_FALLING = 4'b1000
    } gate_t;

    typedef enum logic [1:0] {
        EV_NOTE_ON    = 2'd0,
        EV_NOTE_OFF   = 2'd1,
        EV_AFTERTOUCH = 2'd2
    } kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] threshold_on;
        logic [LEVEL_W-1:0] threshold_off;
        logic [LEVEL_W-1:0] smoothing_weight;
        logic [DELAY_W-1:0] on_delay_ms;
        logic [DELAY_W-1:0] off_delay_ms;
        logic [MIDI_W-1:0]  base_note;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        gate_t              gate_next;
        logic               time_write;
        logic               has_result;
        kind_t              kind;
    } step_t;

    // largest v in 0..127 with v^5 * 2^(3b) <= 127^5 * i^3, used at elaboration only
    function automatic logic [MIDI_W-1:0] curve_entry(input int unsigned i,
                                                      input int unsigned b);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] v5;
        logic [MIDI_W-1:0] best;
        best = '0;
        rhs  = 128'd33038369407 * 128'(i) * 128'(i) * 128'(i);
        for (int v = 1; v < 128; v++) begin
            v5  = 128'(v) * 128'(v) * 128'(v) * 128'(v) * 128'(v);
            lhs = v5 << (3 * b);
            if (lhs <= rhs) begin
                best = MIDI_W'(v);
            end
        end
        return best;
    endfunction

endpackage

// ----- rtl/pvng_if.sv -----
// pvng channel interfaces: sample input, result output and register write
// depends on pvng_pkg for field widths

interface pvng_sample_if import pvng_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PAD_W-1:0]      pad_number;
    logic [PRESSURE_W-1:0] pressure;
    logic [TIME_W-1:0]     time_ms;

    modport source (output valid, pad_number, pressure, time_ms, input ready);
    modport sink   (input valid, pad_number, pressure, time_ms, output ready);
endinterface

interface pvng_result_if import pvng_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [PAD_W-1:0]  pad_out;
    logic [MIDI_W-1:0] note_number;
    logic [MIDI_W-1:0] velocity;
    logic [MIDI_W-1:0] led_level;

    modport source (output valid, event_kind, pad_out, note_number, velocity, led_level,
                    input ready);
    modport sink   (input valid, event_kind, pad_out, note_number, velocity, led_level,
                    output ready);
endinterface

interface pvng_cfg_if import pvng_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pad_velocity_note_gate.sv -----
// pad_velocity_note_gate: pressure pads to note on, note off and aftertouch
// a sample is held in the input register, its result in the output register;
// one sample per cycle while the output is not stalled, with pad state read, updated
// and written back in the same cycle; no-result samples drop after the input register
// reset (rst_n, async low): all pads off at level zero, registers at defaults
// depends on pvng_pkg, pvng_if and the pvng_* submodules

module pad_velocity_note_gate import pvng_pkg::*; #(
    parameter int PAD_COUNT        = 16,
    parameter int TIME_BITS        = 16,
    parameter int CURVE_TABLE_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    pvng_sample_if.sink   sample,
    pvng_result_if.source result,
    pvng_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(PAD_COUNT);

    cfg_t                  regs;

    logic                  in_valid_reg;
    logic [PAD_W-1:0]      in_pad_reg;
    logic [PRESSURE_W-1:0] in_pressure_reg;
    logic [TIME_BITS-1:0]  in_time_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    kind_t                 out_kind_reg;
    logic [PAD_W-1:0]      out_pad_reg;
    logic [MIDI_W-1:0]     out_note_reg;
    logic [MIDI_W-1:0]     out_vel_reg;
    logic [MIDI_W-1:0]     out_led_reg;

    logic                  out_free;
    logic                  advance;
    logic                  pad_ok;
    logic [IDX_W-1:0]      idx;
    logic [LEVEL_W-1:0]    level_old;
    gate_t                 gate_old;
    logic [TIME_BITS-1:0]  time_old;
    step_t                 step;
    logic                  emit;
    logic [MIDI_W-1:0]     note_number;
    logic [MIDI_W-1:0]     velocity;
    logic [MIDI_W-1:0]     led_level;

    pvng_cfg_regs u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = in_valid_reg && out_free;
    assign sample.ready = !in_valid_reg || out_free;

    assign pad_ok = {{(32-PAD_W){1'b0}}, in_pad_reg} < 32'(PAD_COUNT);
    assign idx    = IDX_W'(in_pad_reg);

    pvng_pad_file #(
        .PAD_COUNT(PAD_COUNT),
        .TIME_BITS(TIME_BITS)
    ) u_pads (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (idx),
        .rd_level  (level_old),
        .rd_gate   (gate_old),
        .rd_time   (time_old),
        .wr_en     (advance && pad_ok),
        .wr_level  (step.level),
        .wr_gate   (step.gate_next),
        .wr_time_en(step.time_write),
        .wr_time   (in_time_reg)
    );

    pvng_gate_step #(
        .TIME_BITS(TIME_BITS)
    ) u_gate (
        .regs     (regs),
        .pressure (in_pressure_reg),
        .now      (in_time_reg),
        .level_old(level_old),
        .gate_old (gate_old),
        .time_old (time_old),
        .step     (step)
    );

    pvng_event_fmt #(
        .CURVE_TABLE_BITS(CURVE_TABLE_BITS)
    ) u_fmt (
        .base_note  (regs.base_note),
        .pad        (in_pad_reg),
        .level      (step.level),
        .kind       (step.kind),
        .note_number(note_number),
        .velocity   (velocity),
        .led_level  (led_level)
    );

    assign emit           = advance && pad_ok && step.has_result;
    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_pad_reg      <= sample.pad_number;
            in_pressure_reg <= sample.pressure;
            in_time_reg     <= TIME_BITS'(sample.time_ms);
        end
        if (emit)
        begin
            out_kind_reg <= step.kind;
            out_pad_reg  <= in_pad_reg;
            out_note_reg <= note_number;
            out_vel_reg  <= velocity;
            out_led_reg  <= led_level;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.event_kind  = out_kind_reg;
    assign result.pad_out     = out_pad_reg;
    assign result.note_number = out_note_reg;
    assign result.velocity    = out_vel_reg;
    assign result.led_level   = out_led_reg;

endmodule

// ----- rtl/pvng_cfg_regs.sv -----
// pvng_cfg_regs: configuration register bank written through the cfg channel
// depends on pvng_pkg and pvng_cfg_if

module pvng_cfg_regs import pvng_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pvng_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_THRESHOLD_ON:     regs_next.threshold_on     = cfg.data;
                REG_THRESHOLD_OFF:    regs_next.threshold_off    = cfg.data;
                REG_SMOOTHING_WEIGHT: regs_next.smoothing_weight = cfg.data;
                REG_ON_DELAY_MS:      regs_next.on_delay_ms      = cfg.data[DELAY_W-1:0];
                REG_OFF_DELAY_MS:     regs_next.off_delay_ms     = cfg.data[DELAY_W-1:0];
                REG_BASE_NOTE:        regs_next.base_note        = cfg.data[MIDI_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.threshold_on     <= THRESHOLD_ON_RST;
            regs_reg.threshold_off    <= THRESHOLD_OFF_RST;
            regs_reg.smoothing_weight <= SMOOTHING_WEIGHT_RST;
            regs_reg.on_delay_ms      <= ON_DELAY_RST;
            regs_reg.off_delay_ms     <= OFF_DELAY_RST;
            regs_reg.base_note        <= BASE_NOTE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/pvng_pad_file.sv -----
// pvng_pad_file: per-pad state (smoothed level, gate state, change time)
// depends on pvng_pkg

module pvng_pad_file import pvng_pkg::*; #(
    parameter int PAD_COUNT = 16,
    parameter int TIME_BITS = 16,
    localparam int IDX_W    = $clog2(PAD_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     idx,
    output logic [LEVEL_W-1:0]   rd_level,
    output gate_t                rd_gate,
    output logic [TIME_BITS-1:0] rd_time,
    input  logic                 wr_en,
    input  logic [LEVEL_W-1:0]   wr_level,
    input  gate_t                wr_gate,
    input  logic                 wr_time_en,
    input  logic [TIME_BITS-1:0] wr_time
);

    logic [LEVEL_W-1:0]   level_reg [PAD_COUNT];
    gate_t                gate_reg  [PAD_COUNT];
    logic [TIME_BITS-1:0] time_reg  [PAD_COUNT];

    assign rd_level = level_reg[idx];
    assign rd_gate  = gate_reg[idx];
    assign rd_time  = time_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                level_reg[p] <= '0;
                gate_reg[p]  <= GATE_OFF;
            end
        end
        else if (wr_en)
        begin
            level_reg[idx] <= wr_level;
            gate_reg[idx]  <= wr_gate;
        end
    end

    // change time is only read after the gate has written it
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_time_en)
        begin
            time_reg[idx] <= wr_time;
        end
    end

endmodule

// ----- rtl/pvng_gate_step.sv -----
// pvng_gate_step: exponential smoothing and the four-state hysteresis gate
// depends on pvng_pkg

module pvng_gate_step import pvng_pkg::*; #(
    parameter int TIME_BITS = 16
) (
    input  cfg_t                  regs,
    input  logic [PRESSURE_W-1:0] pressure,
    input  logic [TIME_BITS-1:0]  now,
    input  logic [LEVEL_W-1:0]    level_old,
    input  gate_t                 gate_old,
    input  logic [TIME_BITS-1:0]  time_old,
    output step_t                 step
);

    logic [LEVEL_W-1:0]   x;
    logic signed [17:0]   diff;
    logic [16:0]          keep_new;
    logic signed [17:0]   coef;
    logic signed [35:0]   prod;
    logic signed [35:0]   rounded;
    logic signed [19:0]   level_sum;
    logic [LEVEL_W-1:0]   level;
    logic [TIME_BITS-1:0] elapsed;
    logic                 on_held;
    logic                 off_held;

    // L' = L + round((65536 - w) * (x - L) / 65536), same as the weighted sum
    assign x         = {pressure, 4'b0000};
    assign diff      = $signed({2'b00, x}) - $signed({2'b00, level_old});
    assign keep_new  = 17'h10000 - {1'b0, regs.smoothing_weight};
    assign coef      = $signed({1'b0, keep_new});
    assign prod      = diff * coef;
    assign rounded   = prod + 36'sd32768;
    assign level_sum = $signed({4'b0000, level_old}) + rounded[35:16];
    assign level     = level_sum[LEVEL_W-1:0];

    assign elapsed  = now - time_old;
    assign on_held  = elapsed >= TIME_BITS'(regs.on_delay_ms);
    assign off_held = elapsed >= TIME_BITS'(regs.off_delay_ms);

    always_comb
    begin
        step.level      = level;
        step.gate_next  = gate_old;
        step.time_write = 1'b0;
        step.has_result = 1'b0;
        step.kind       = EV_AFTERTOUCH;
        // release test first so crossed thresholds resolve to release
        priority if (level < regs.threshold_off)
        begin
            unique case (gate_old)
                GATE_RISING: step.gate_next = GATE_OFF;
                GATE_ON:
                begin
                    step.gate_next  = GATE_FALLING;
                    step.time_write = 1'b1;
                    step.has_result = 1'b1;
                end
                GATE_FALLING:
                begin
                    step.has_result = 1'b1;
                    if (off_held)
                    begin
                        step.gate_next = GATE_OFF;
                        step.kind      = EV_NOTE_OFF;
                    end
                end
                default: ;
            endcase
        end
        else if (level > regs.threshold_on)
        begin
            unique case (gate_old)
                GATE_OFF:
                begin
                    step.gate_next  = GATE_RISING;
                    step.time_write = 1'b1;
                end
                GATE_RISING:
                begin
                    if (on_held)
                    begin
                        step.gate_next  = GATE_ON;
                        step.has_result = 1'b1;
                        step.kind       = EV_NOTE_ON;
                    end
                end
                GATE_ON, GATE_FALLING:
                begin
                    step.gate_next  = GATE_ON;
                    step.has_result = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
        end
    end

endmodule

// ----- rtl/pvng_event_fmt.sv -----
// pvng_event_fmt: grid note number and velocity curve lookup for one result
// depends on pvng_pkg (curve_entry builds the table at elaboration)

module pvng_event_fmt import pvng_pkg::*; #(
    parameter int CURVE_TABLE_BITS = 8,
    localparam int CURVE_SIZE      = 1 << CURVE_TABLE_BITS
) (
    input  logic [MIDI_W-1:0]  base_note,
    input  logic [PAD_W-1:0]   pad,
    input  logic [LEVEL_W-1:0] level,
    input  kind_t              kind,
    output logic [MIDI_W-1:0]  note_number,
    output logic [MIDI_W-1:0]  velocity,
    output logic [MIDI_W-1:0]  led_level
);

    logic [MIDI_W-1:0] curve_rom [CURVE_SIZE];
    logic [1:0]        row_up;

    for (genvar g = 0; g < CURVE_SIZE; g++)
    begin : g_curve
        assign curve_rom[g] = curve_entry(g, CURVE_TABLE_BITS);
    end

    // rows count from the top, notes rise from the bottom row
    assign row_up      = 2'd3 - pad[3:2];
    assign note_number = base_note + {3'b000, row_up, 2'b00} + {5'b00000, pad[1:0]};
    assign velocity    = curve_rom[level[LEVEL_W-1 -: CURVE_TABLE_BITS]];
    assign led_level   = (kind == EV_NOTE_OFF) ? '0 : velocity;

endmodule
